>>> design/pclt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the per-config packet loss tracker.
// No dependencies; pclt_cell and the top level import this package.
package pclt_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam logic [31:0] BASE_UNSET = 32'hFFFF_FFFF;
  localparam logic [7:0] MIN_LENGTH = 8'd6;  // lengths at or below this are dropped

  // Frame context broadcast to every cell while a search runs.
  typedef struct packed {
    logic [7:0]  cfg;
    logic [31:0] id;
    logic [31:0] base;
    logic        gt;     // id above base
  } query_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic        valid;
    logic        done;      // some cell claimed the frame
    logic        appended;  // claiming cell took a fresh entry
    logic        report;    // a result word must go out
    logic [31:0] pass;
    logic [31:0] fail;
  } tok_t;

  // One result word.
  typedef struct packed {
    logic [7:0]  cfg;
    logic [31:0] id;
    logic [31:0] pass;
    logic [31:0] fail;
  } res_t;

endpackage

>>> design/pclt_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for frame headers and result words.
// Depends on nothing; used by the top level.
interface pclt_frame_if;
  logic        valid;
  logic        ready;
  logic        restart;
  logic [7:0]  frame_length;
  logic [7:0]  config_byte;
  logic [31:0] packet_id;
  logic        crc_ok;

  modport source (output valid, restart, frame_length, config_byte, packet_id, crc_ok,
                  input ready);
  modport sink (input valid, restart, frame_length, config_byte, packet_id, crc_ok,
                output ready);
endinterface

interface pclt_report_if;
  logic        valid;
  logic        ready;
  logic [7:0]  report_config;
  logic [31:0] report_id;
  logic [31:0] pass_total;
  logic [31:0] fail_total;

  modport source (output valid, report_config, report_id, pass_total, fail_total,
                  input ready);
  modport sink (input valid, report_config, report_id, pass_total, fail_total,
                output ready);
endinterface

>>> design/pclt_cell.sv
`timescale 1ns / 1ps
// One table entry of the tracker: key, last id and the two totals.
// Depends on pclt_pkg.
module pclt_cell import pclt_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int INDEX = 0,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  query_t        query,
  input  logic [CW-1:0] count,
  input  tok_t          tok_in,
  output tok_t          tok_out
);

  localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

  logic [7:0]  key;
  logic [31:0] last_id;
  logic [31:0] fail;
  logic [31:0] pass;

  logic        occupied;
  logic        live;
  logic        hit;
  logic        append;
  logic        match;
  logic [31:0] last_eff;
  logic [31:0] fail_eff;
  logic [31:0] pass_eff;
  logic [31:0] fail_sum;
  logic [31:0] pass_sum;

  always_comb begin
    occupied = MY_IDX < count;
    live     = tok_in.valid && !tok_in.done;
    hit      = live && occupied && (key == query.cfg);
    append   = live && !occupied && (MY_IDX == count);
    match    = hit || append;
    last_eff = append ? query.base : last_id;
    fail_eff = append ? 32'd0 : fail;
    pass_eff = append ? 32'd0 : pass;
    // gap = id - last - 1 = id + ~last
    fail_sum = fail_eff + query.id + ~last_eff;
    pass_sum = pass_eff + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (append) begin
      key <= query.cfg;
    end
    if (match && query.gt) begin
      last_id <= query.id;
      fail    <= fail_sum;
      pass    <= pass_sum;
    end else if (append) begin
      last_id <= query.base;
      fail    <= 32'd0;
      pass    <= 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_in;
      if (match) begin
        tok_out.done     <= 1'b1;
        tok_out.appended <= append;
        tok_out.report   <= query.gt;
        tok_out.pass     <= pass_sum;
        tok_out.fail     <= fail_sum;
      end
    end
  end

endmodule

>>> design/per_config_packet_loss_tracker.sv
`timescale 1ns / 1ps
// Per-configuration packet loss tracker. Each frame header word is checked for
// length (more than 6 bytes) and CRC; dropped frames do not block intake and only
// apply their restart flag. A counted frame sets the base id if unset, then a
// search token walks a row of TABLE_DEPTH cells, one cell per cycle. The cell
// holding the frame's configuration byte, or the first free cell when the key
// is absent and the table has room, claims the token and hands its new pass
// and fail totals (mod 2^32) down the row. It keeps them, with the id as its
// last id, only for ids above the base; a result word comes out only for these.
// A counted frame occupies the block until its token leaves the last cell;
// frame.ready stays low meanwhile. One finished result can wait in a holding
// register while the output register is stalled, so a new frame is taken
// before the last result is drained; only a second pending result blocks input.
// Restart empties the table at once through the fill count; no clearing pass.
// Depends on pclt_pkg, pclt_ifs and pclt_cell.
module per_config_packet_loss_tracker import pclt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input logic           clk,
  input logic           rst,
  pclt_frame_if.sink    frame,
  pclt_report_if.source report
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // control
  logic          busy;
  logic          launch;
  logic [CW-1:0] count;
  logic [31:0]   base_id;
  logic          out_valid;
  logic          hold_valid;

  // payload
  query_t query;
  res_t   out_res;
  res_t   hold_res;

  logic        accept;
  logic        counted;
  logic [31:0] base_eff;
  logic [31:0] base_next;
  tok_t        head;
  tok_t        chain [TABLE_DEPTH+1];
  tok_t        tail;
  res_t        tail_res;

  assign frame.ready = !busy && !hold_valid;
  assign accept      = frame.valid && frame.ready;
  assign counted     = (frame.frame_length > MIN_LENGTH) && frame.crc_ok;

  always_comb begin
    base_eff  = frame.restart ? BASE_UNSET : base_id;
    base_next = (counted && base_eff == BASE_UNSET) ? frame.packet_id : base_eff;
  end

  // token entering the first cell
  always_comb begin
    head       = '0;
    head.valid = launch;
  end

  assign chain[0] = head;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      pclt_cell #(
        .DEPTH (TABLE_DEPTH),
        .INDEX (g)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .query   (query),
        .count   (count),
        .tok_in  (chain[g]),
        .tok_out (chain[g+1])
      );
    end
  endgenerate

  assign tail = chain[TABLE_DEPTH];

  always_comb begin
    tail_res.cfg  = query.cfg;
    tail_res.id   = query.id;
    tail_res.pass = tail.pass;
    tail_res.fail = tail.fail;
  end

  // frame intake, base id, fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      launch  <= 1'b0;
      count   <= '0;
      base_id <= BASE_UNSET;
    end else begin
      launch <= 1'b0;
      if (accept) begin
        base_id <= base_next;
        if (frame.restart) begin
          count <= '0;
        end
        if (counted) begin
          busy   <= 1'b1;
          launch <= 1'b1;
        end
      end
      if (tail.valid) begin
        busy <= 1'b0;
        if (tail.appended) begin
          count <= count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && counted) begin
      query.cfg  <= frame.config_byte;
      query.id   <= frame.packet_id;
      query.base <= base_next;
      query.gt   <= frame.packet_id > base_next;
    end
  end

  // output register plus one holding slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (out_valid && report.ready) begin
        out_valid <= 1'b0;
      end
      if (hold_valid && (!out_valid || report.ready)) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else if (tail.valid && tail.report) begin
        if (!out_valid || report.ready) begin
          out_valid <= 1'b1;
        end else begin
          hold_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_valid && (!out_valid || report.ready)) begin
      out_res <= hold_res;
    end else if (tail.valid && tail.report) begin
      if (!out_valid || report.ready) begin
        out_res <= tail_res;
      end else begin
        hold_res <= tail_res;
      end
    end
  end

  assign report.valid         = out_valid;
  assign report.report_config = out_res.cfg;
  assign report.report_id     = out_res.id;
  assign report.pass_total    = out_res.pass;
  assign report.fail_total    = out_res.fail;

endmodule

>>> design/pclt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the packet loss tracker, bound to the top level.
// Depends on per_config_packet_loss_tracker and pclt_ifs.
module pclt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  frame_length,
  input logic        crc_ok,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  report_config,
  input logic [31:0] report_id,
  input logic [31:0] pass_total,
  input logic [31:0] fail_total
);

  // no result word right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  // a counted frame starts a table walk, so intake stops next cycle
  a_walk_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && crc_ok && frame_length > 8'd6) |=> !in_ready)
    else $error("frame taken during table walk");

  // reported ids are above the base, so never zero
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> report_id != 32'd0)
    else $error("result word with zero packet id");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(report_config) &&
      $stable(report_id) && $stable(pass_total) && $stable(fail_total)))
    else $error("stalled result word changed");

endmodule

bind per_config_packet_loss_tracker pclt_checker u_pclt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (frame.valid),
  .in_ready      (frame.ready),
  .frame_length  (frame.frame_length),
  .crc_ok        (frame.crc_ok),
  .out_valid     (report.valid),
  .out_ready     (report.ready),
  .report_config (report.report_config),
  .report_id     (report.report_id),
  .pass_total    (report.pass_total),
  .fail_total    (report.fail_total)
);
